// File: hdl/irct_pkg.sv
// irct_pkg: shared types, codes and helpers for the IRC message tokenizer.
// No dependencies; used by every irct_* module and the top level.
`timescale 1ns / 1ps

package irct_pkg;

   localparam int MaxParamsDefault  = 16;
   localparam int QueueDepthDefault = 4;

   localparam logic [7:0] CharColon = 8'h3A;
   localparam logic [7:0] CharSpace = 8'h20;
   localparam logic [7:0] CharComma = 8'h2C;

   // field kinds; the parse stage reuses the first three
   localparam logic [1:0] KindPrefix   = 2'd0;
   localparam logic [1:0] KindCommand  = 2'd1;
   localparam logic [1:0] KindMiddle   = 2'd2;
   localparam logic [1:0] KindTrailing = 2'd3;

   // classified byte: optional character item, optional empty trailing item
   typedef struct packed {
      logic [7:0] ch;
      logic       has_a;
      logic [1:0] kind_a;
      logic [3:0] idx_a;
      logic       start_a;
      logic       end_a;
      logic       has_b;
      logic [3:0] idx_b;
      logic       prefix;
   } irct_rec_type;

   typedef struct packed {
      logic any_seen;
      logic [3:0] count;
   } irct_param_type;

   function automatic irct_param_type next_param(input irct_param_type cur,
                                                 input logic [3:0] limit);
      irct_param_type nxt;
      nxt = cur;
      if (cur.any_seen) begin
         if (cur.count < limit) nxt.count = cur.count + 4'd1;
      end else begin
         nxt.any_seen = 1'b1;
      end
      return nxt;
   endfunction

endpackage

// File: hdl/irct_front.sv
// irct_front: per-byte parser state; classifies each accepted beat into a record.
// Depends on irct_pkg.
`timescale 1ns / 1ps

module irct_front #(
   parameter int MAX_PARAMS = irct_pkg::MaxParamsDefault
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic [7:0]            data_byte,
   input  logic                  last_byte,
   output logic                  push,
   output irct_pkg::irct_rec_type rec
);
   import irct_pkg::*;

   localparam logic [3:0] IdxLimit = (MAX_PARAMS - 1 > 15) ? 4'd15 : 4'(MAX_PARAMS - 1);

   logic [1:0]     stage_ff, stage_in;
   logic           inside_ff, inside_in;
   logic           mstart_ff, mstart_in;
   logic           prefix_ff, prefix_in;
   logic           trail_ff, trail_in;
   logic           topen_ff, topen_in;
   irct_param_type param_ff, param_in;

   always_comb begin
      logic consumed;
      logic [1:0] kind;
      stage_in  = stage_ff;
      inside_in = inside_ff;
      mstart_in = mstart_ff;
      prefix_in = prefix_ff;
      trail_in  = trail_ff;
      topen_in  = topen_ff;
      param_in  = param_ff;
      rec       = '0;
      consumed  = 1'b0;
      kind      = KindPrefix;

      if (mstart_ff) begin
         mstart_in = 1'b0;
         if (data_byte == CharColon) begin
            prefix_in = 1'b1;
            stage_in  = KindPrefix;
            consumed  = 1'b1;
         end else begin
            stage_in = KindCommand;
         end
      end

      if (!consumed) begin
         if (trail_ff) begin
            rec.has_a   = 1'b1;
            rec.kind_a  = KindTrailing;
            rec.idx_a   = param_in.count;
            rec.start_a = !topen_ff;
            rec.end_a   = last_byte;
            topen_in    = 1'b1;
         end else if (data_byte == CharColon) begin
            inside_in = 1'b0;
            trail_in  = 1'b1;
            param_in  = next_param(param_in, IdxLimit);
         end else if (data_byte == CharSpace ||
                      (data_byte == CharComma && stage_in >= KindMiddle)) begin
            if (inside_ff) begin
               inside_in = 1'b0;
               if (data_byte == CharSpace && stage_in < KindMiddle)
                  stage_in = stage_in + 2'd1;
            end
         end else begin
            kind = stage_in;
            if (!inside_ff) begin
               inside_in   = 1'b1;
               rec.start_a = 1'b1;
               if (kind == KindMiddle) param_in = next_param(param_in, IdxLimit);
            end
            rec.has_a  = 1'b1;
            rec.kind_a = kind;
            rec.idx_a  = (kind == KindMiddle) ? param_in.count : 4'd0;
         end
      end
      rec.ch     = data_byte;
      rec.prefix = prefix_in;

      if (last_byte) begin
         if (!topen_in) begin
            if (!trail_in) param_in = next_param(param_in, IdxLimit);
            rec.has_b = 1'b1;
            rec.idx_b = param_in.count;
         end
         stage_in  = KindPrefix;
         inside_in = 1'b0;
         mstart_in = 1'b1;
         prefix_in = 1'b0;
         trail_in  = 1'b0;
         topen_in  = 1'b0;
         param_in  = '0;
      end
   end

   assign push = accept && (rec.has_a || rec.has_b);

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff  <= KindPrefix;
         inside_ff <= 1'b0;
         mstart_ff <= 1'b1;
         prefix_ff <= 1'b0;
         trail_ff  <= 1'b0;
         topen_ff  <= 1'b0;
         param_ff  <= '0;
      end else if (accept) begin
         stage_ff  <= stage_in;
         inside_ff <= inside_in;
         mstart_ff <= mstart_in;
         prefix_ff <= prefix_in;
         trail_ff  <= trail_in;
         topen_ff  <= topen_in;
         param_ff  <= param_in;
      end
   end

endmodule

// File: hdl/irct_queue.sv
// irct_queue: small FIFO of classified records between front and back.
// Depends on irct_pkg.
`timescale 1ns / 1ps

module irct_queue #(
   parameter int QUEUE_DEPTH = irct_pkg::QueueDepthDefault
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  irct_pkg::irct_rec_type push_rec,
   input  logic                   pop,
   output irct_pkg::irct_rec_type pop_rec,
   output logic                   full,
   output logic                   empty
);
   import irct_pkg::*;

   localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CntW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PtrW-1:0] PtrLast = PtrW'(QUEUE_DEPTH - 1);
   localparam logic [CntW-1:0] CntFull = CntW'(QUEUE_DEPTH);

   irct_rec_type    entry_ff [QUEUE_DEPTH];
   logic [PtrW-1:0] wr_ff, wr_in;
   logic [PtrW-1:0] rd_ff, rd_in;
   logic [CntW-1:0] cnt_ff, cnt_in;

   assign full    = (cnt_ff == CntFull);
   assign empty   = (cnt_ff == '0);
   assign pop_rec = entry_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) wr_in = (wr_ff == PtrLast) ? '0 : wr_ff + 1'b1;
      if (pop)  rd_in = (rd_ff == PtrLast) ? '0 : rd_ff + 1'b1;
      if (push && !pop) cnt_in = cnt_ff + 1'b1;
      else if (pop && !push) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ff] <= push_rec;
   end

endmodule

// File: hdl/irct_back.sv
// irct_back: expands records into result beats behind an output register.
// Depends on irct_pkg.
`timescale 1ns / 1ps

module irct_back (
   input  logic                   clock,
   input  logic                   reset,
   input  irct_pkg::irct_rec_type rec,
   input  logic                   empty,
   output logic                   pop,
   output logic                   out_valid,
   input  logic                   out_stall,
   output logic [7:0]             char_out,
   output logic                   byte_valid,
   output logic [1:0]             field_kind,
   output logic [3:0]             param_index,
   output logic                   token_start,
   output logic                   message_end,
   output logic                   prefix_present
);
   import irct_pkg::*;

   logic       valid_ff, valid_in;
   logic       pend_ff, pend_in;
   logic [3:0] pidx_ff, pidx_in;
   logic       ppre_ff, ppre_in;
   logic       load;
   logic [7:0] ch_ff, ch_in;
   logic       bv_ff, bv_in;
   logic [1:0] kind_ff, kind_in;
   logic [3:0] idx_ff, idx_in;
   logic       st_ff, st_in;
   logic       end_ff, end_in;
   logic       pre_ff, pre_in;

   always_comb begin
      load     = !valid_ff || !out_stall;
      pop      = load && !pend_ff && !empty;
      valid_in = valid_ff;
      pend_in  = pend_ff;
      pidx_in  = pidx_ff;
      ppre_in  = ppre_ff;
      ch_in    = '0;
      bv_in    = 1'b0;
      kind_in  = KindTrailing;
      idx_in   = pidx_ff;
      st_in    = 1'b1;
      end_in   = 1'b1;
      pre_in   = ppre_ff;
      if (load) begin
         if (pend_ff) begin
            valid_in = 1'b1;
            pend_in  = 1'b0;
         end else if (!empty) begin
            valid_in = 1'b1;
            pidx_in  = rec.idx_b;
            ppre_in  = rec.prefix;
            pre_in   = rec.prefix;
            if (rec.has_a) begin
               pend_in = rec.has_b;
               ch_in   = rec.ch;
               bv_in   = 1'b1;
               kind_in = rec.kind_a;
               idx_in  = rec.idx_a;
               st_in   = rec.start_a;
               end_in  = rec.end_a;
            end else begin
               idx_in = rec.idx_b;
            end
         end else begin
            valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         pend_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      pidx_ff <= pidx_in;
      ppre_ff <= ppre_in;
      if (load) begin
         ch_ff   <= ch_in;
         bv_ff   <= bv_in;
         kind_ff <= kind_in;
         idx_ff  <= idx_in;
         st_ff   <= st_in;
         end_ff  <= end_in;
         pre_ff  <= pre_in;
      end
   end

   assign out_valid      = valid_ff;
   assign char_out       = ch_ff;
   assign byte_valid     = bv_ff;
   assign field_kind     = kind_ff;
   assign param_index    = idx_ff;
   assign token_start    = st_ff;
   assign message_end    = end_ff;
   assign prefix_present = pre_ff;

endmodule

// File: hdl/irc_message_tokenizer.sv
// irc_message_tokenizer: top level; front parser, record queue, output expander.
// Depends on irct_pkg, irct_front, irct_queue, irct_back.
//
//   channel  direction  handshake             beat
//   req_     in         req_valid/req_stall   data_byte, last_byte
//   rsp_     out        rsp_valid/rsp_stall   char_out .. prefix_present
//
// One input byte per cycle is parsed and classified in the front the cycle it is taken
// while the queue is not full. A byte yields zero, one or two result beats; the output
// stage sends one beat per cycle unless stalled, a character beat before a trailing one.
// Synchronous reset returns the parser to message start and empties the queue.
// req_stall rises only when the record queue is full.
`timescale 1ns / 1ps

module irc_message_tokenizer #(
   parameter int MAX_PARAMS  = irct_pkg::MaxParamsDefault,
   parameter int QUEUE_DEPTH = irct_pkg::QueueDepthDefault
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_last_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_char_out,
   output logic       rsp_byte_valid,
   output logic [1:0] rsp_field_kind,
   output logic [3:0] rsp_param_index,
   output logic       rsp_token_start,
   output logic       rsp_message_end,
   output logic       rsp_prefix_present
);
   import irct_pkg::*;

   logic         accept;
   logic         push;
   logic         pop;
   logic         full;
   logic         empty;
   irct_rec_type front_rec;
   irct_rec_type queue_rec;

   assign req_stall = full;
   assign accept    = req_valid && !full;

   irct_front #(.MAX_PARAMS(MAX_PARAMS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .data_byte (req_data_byte),
      .last_byte (req_last_byte),
      .push      (push),
      .rec       (front_rec)
   );

   irct_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_rec (front_rec),
      .pop      (pop),
      .pop_rec  (queue_rec),
      .full     (full),
      .empty    (empty)
   );

   irct_back u_back (
      .clock          (clock),
      .reset          (reset),
      .rec            (queue_rec),
      .empty          (empty),
      .pop            (pop),
      .out_valid      (rsp_valid),
      .out_stall      (rsp_stall),
      .char_out       (rsp_char_out),
      .byte_valid     (rsp_byte_valid),
      .field_kind     (rsp_field_kind),
      .param_index    (rsp_param_index),
      .token_start    (rsp_token_start),
      .message_end    (rsp_message_end),
      .prefix_present (rsp_prefix_present)
   );

endmodule

// File: dv/irct_checker.sv
// irct_checker: watches both channels of irc_message_tokenizer, predicts the response
// beats of every accepted byte and compares them field by field in order.
// Depends on irct_pkg.
`timescale 1ns / 1ps

module irct_checker #(
   parameter int MAX_PARAMS = irct_pkg::MaxParamsDefault
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_last_byte,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic [7:0] rsp_char_out,
   input  logic       rsp_byte_valid,
   input  logic [1:0] rsp_field_kind,
   input  logic [3:0] rsp_param_index,
   input  logic       rsp_token_start,
   input  logic       rsp_message_end,
   input  logic       rsp_prefix_present,
   output int         fail_count,
   output int         pending
);
   import irct_pkg::*;

   localparam logic [3:0] IdxLimit = (MAX_PARAMS - 1 > 15) ? 4'd15 : 4'(MAX_PARAMS - 1);

   typedef struct packed {
      logic [7:0] ch;
      logic       valid;
      logic [1:0] kind;
      logic [3:0] idx;
      logic       start;
      logic       msg_end;
      logic       pfx;
   } tok_beat_type;

   tok_beat_type token_beats_q[$];
   int           fails = 0;

   // parser state
   logic [1:0] stage       = KindPrefix;
   logic       in_tok      = 1'b0;
   logic       msg_start   = 1'b1;
   logic       has_pfx     = 1'b0;
   logic       in_trl      = 1'b0;
   logic       trl_open    = 1'b0;
   logic [3:0] param_idx   = 4'd0;
   logic       param_seen  = 1'b0;

   function void clear_parse_state();
      stage      = KindPrefix;
      in_tok     = 1'b0;
      msg_start  = 1'b1;
      has_pfx    = 1'b0;
      in_trl     = 1'b0;
      trl_open   = 1'b0;
      param_idx  = 4'd0;
      param_seen = 1'b0;
   endfunction

   function void advance_param_index();
      if (param_seen) begin
         if (param_idx < IdxLimit) param_idx = param_idx + 4'd1;
      end else begin
         param_seen = 1'b1;
      end
   endfunction

   function void push_beat(logic [7:0] ch, logic valid, logic [1:0] kind, logic [3:0] idx,
                           logic start, logic msg_end);
      tok_beat_type b;
      b = '{ch: ch, valid: valid, kind: kind, idx: idx, start: start, msg_end: msg_end,
            pfx: has_pfx};
      token_beats_q = {token_beats_q, b};
   endfunction

   function void tokenize_byte(logic [7:0] c, logic is_last);
      logic       consumed;
      logic [1:0] kind;
      logic       start;
      consumed = 1'b0;
      if (msg_start) begin
         msg_start = 1'b0;
         if (c == CharColon) begin
            has_pfx  = 1'b1;
            stage    = KindPrefix;
            consumed = 1'b1;
         end else begin
            stage = KindCommand;
         end
      end
      if (!consumed) begin
         if (in_trl) begin
            push_beat(c, 1'b1, KindTrailing, param_idx, !trl_open, is_last);
            trl_open = 1'b1;
         end else if (c == CharColon) begin
            in_tok = 1'b0;
            in_trl = 1'b1;
            advance_param_index();
         end else if (c == CharSpace || (c == CharComma && stage == KindMiddle)) begin
            if (in_tok) begin
               in_tok = 1'b0;
               if (c == CharSpace && stage != KindMiddle) stage = stage + 2'd1;
            end
         end else begin
            kind  = stage;
            start = 1'b0;
            if (!in_tok) begin
               in_tok = 1'b1;
               start  = 1'b1;
               if (kind == KindMiddle) advance_param_index();
            end
            push_beat(c, 1'b1, kind, (kind == KindMiddle) ? param_idx : 4'd0, start, 1'b0);
         end
      end
      if (is_last) begin
         if (!trl_open) begin
            if (!in_trl) advance_param_index();
            push_beat(8'd0, 1'b0, KindTrailing, param_idx, 1'b1, 1'b1);
         end
         clear_parse_state();
      end
   endfunction

   function void check_field(string name, logic [7:0] exp_val, logic [7:0] act_val);
      if (exp_val !== act_val) begin
         $error("%s: expected %0h, got %0h", name, exp_val, act_val);
         fails++;
      end
   endfunction

   always @(posedge clock) begin : monitor
      tok_beat_type want;
      if (reset) begin
         token_beats_q.delete();
         clear_parse_state();
      end else begin
         if (req_valid && !req_stall) tokenize_byte(req_data_byte, req_last_byte);
         if (rsp_valid && !rsp_stall) begin
            if (token_beats_q.size() == 0) begin
               $error("unexpected response beat: char_out %0h", rsp_char_out);
               fails++;
            end else begin
               want = token_beats_q.pop_front();
               check_field("char_out", want.ch, rsp_char_out);
               check_field("byte_valid", want.valid, rsp_byte_valid);
               check_field("field_kind", want.kind, rsp_field_kind);
               check_field("param_index", want.idx, rsp_param_index);
               check_field("token_start", want.start, rsp_token_start);
               check_field("message_end", want.msg_end, rsp_message_end);
               check_field("prefix_present", want.pfx, rsp_prefix_present);
            end
         end
      end
      fail_count <= fails;
      pending    <= token_beats_q.size();
   end

endmodule

// File: dv/tb.sv
// tb: top level for irc_message_tokenizer; drives message bytes, random response stalls
// and a watchdog, and gives the verdict. Depends on irct_pkg, irct_checker and the RTL.
`timescale 1ns / 1ps

module tb;
   import irct_pkg::*;

   localparam int IdleLimit  = 2000;
   localparam int ByteTarget = 1550;

   logic       clock         = 1'b0;
   logic       reset         = 1'b1;
   logic       req_valid     = 1'b0;
   logic [7:0] req_data_byte = 8'd0;
   logic       req_last_byte = 1'b0;
   logic       rsp_stall     = 1'b0;
   logic       req_stall;
   logic       rsp_valid;
   logic [7:0] rsp_char_out;
   logic       rsp_byte_valid;
   logic [1:0] rsp_field_kind;
   logic [3:0] rsp_param_index;
   logic       rsp_token_start;
   logic       rsp_message_end;
   logic       rsp_prefix_present;
   int         fail_count;
   int         pending;

   bit         no_idle       = 1'b0;
   bit         long_hold_req = 1'b0;
   int         bytes_sent    = 0;
   logic [7:0] msg_bytes[$];

   irc_message_tokenizer i_dut (.*);
   irct_checker i_checker (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin : watchdog
      int idle;
      idle = 0;
      while (idle < IdleLimit) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle = 0;
         else idle++;
      end
      $display("status: fail");
      $finish;
   end

   initial begin : receiver
      int hold;
      int r;
      hold = 0;
      forever begin
         @(posedge clock);
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold = 300;
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            hold--;
         end else if (no_idle) begin
            rsp_stall <= 1'b0;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 65) begin
               rsp_stall <= 1'b0;
            end else begin
               rsp_stall <= 1'b1;
               hold = (r < 95) ? $urandom_range(0, 3) : $urandom_range(5, 30);
            end
         end
      end
   end

   function int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(5, 30);
   endfunction

   function logic [7:0] token_char();
      logic [7:0] c;
      if ($urandom_range(0, 99) < 20) begin
         c = 8'($urandom_range(0, 255));
         while (c == CharSpace || c == CharColon || c == CharComma)
            c = 8'($urandom_range(0, 255));
      end else begin
         c = 8'($urandom_range(8'h61, 8'h7A));
      end
      return c;
   endfunction

   function logic [7:0] any_char();
      case ($urandom_range(0, 5))
         0: return CharColon;
         1: return CharSpace;
         2: return CharComma;
         default: return token_char();
      endcase
   endfunction

   function void add_byte(logic [7:0] b);
      msg_bytes = {msg_bytes, b};
   endfunction

   function void add_str(string s);
      for (int i = 0; i < s.len(); i++) add_byte(s[i]);
   endfunction

   function void add_token(int lo, int hi);
      repeat ($urandom_range(lo, hi)) add_byte(token_char());
   endfunction

   // mostly well-formed lines with random content, some raw separator noise
   function void build_random_message();
      int n;
      int r;
      msg_bytes.delete();
      if ($urandom_range(0, 99) < 15) begin
         repeat ($urandom_range(1, 10)) add_byte(any_char());
         return;
      end
      if ($urandom_range(0, 1)) begin
         add_byte(CharColon);
         add_token(1, 6);
         if ($urandom_range(0, 3) == 0) add_str("  ");
         else add_str(" ");
      end
      add_token(1, 6);
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 20) : $urandom_range(0, 4);
      for (int i = 0; i < n; i++) begin
         if (i == 0) add_str(" ");
         else begin
            case ($urandom_range(0, 3))
               0: add_str(" ");
               1: add_str(",");
               2: add_str(" ,");
               default: add_str(",,");
            endcase
         end
         add_token(1, 4);
      end
      r = $urandom_range(0, 99);
      if (r < 60) begin
         add_str(" :");
         repeat ($urandom_range(0, 8)) add_byte(any_char());
      end else if (r < 75) begin
         add_str(" ");
      end
   endfunction

   task send_beat(logic [7:0] c, logic is_last);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= c;
      req_last_byte <= is_last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      bytes_sent++;
   endtask

   task send_message();
      for (int i = 0; i < msg_bytes.size(); i++)
         send_beat(msg_bytes[i], i == msg_bytes.size() - 1);
      msg_bytes.delete();
   endtask

   task drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   initial begin : stimulus
      int msgs;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      add_str(":");
      send_message();
      add_str("A");
      send_message();
      add_str(":p,q C  a,,b:x: ,");
      send_message();
      add_byte(8'h00);
      add_byte(8'hFF);
      send_message();
      add_str("C :");
      send_message();
      add_str("x ");
      send_message();
      drain();

      // receiver backs off while bytes keep coming, so the block fills
      long_hold_req = 1'b1;
      msgs = 0;
      while (bytes_sent < ByteTarget) begin
         if (msgs % 12 == 0) no_idle = ($urandom_range(0, 2) == 0);
         if (msgs == 40) drain();
         if (msgs == 60) long_hold_req = 1'b1;
         build_random_message();
         send_message();
         msgs++;
      end

      drain();
      repeat (20) @(posedge clock);
      if (fail_count == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

endmodule
